[design/lcs_pkg.sv]
package lcs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int EW        = 32;
   localparam int LIM_W     = 31;
   localparam int CW        = 2 * EW + 1;
   localparam int LO_W      = 33;
   localparam int DETW      = CW + EW;
   localparam int QBITS     = 32;
   localparam int RW        = DETW + QBITS;
   localparam int DET_LAT   = 5;
   localparam int DIV_LAT   = QBITS + 3;
   localparam int PIPE_LAT  = DET_LAT + DIV_LAT;
   localparam int AW        = 3;

   localparam logic [AW-1:0] REG_SINGULAR_LIMIT = 3'd0;

   typedef logic signed [EW-1:0]   elem_type;
   typedef logic signed [DETW-1:0] det_type;

endpackage

[design/lcs_det3.sv]
module lcs_det3 (
   input  logic             clock,
   input  logic             en,
   input  lcs_pkg::elem_type m [9],
   output lcs_pkg::det_type  det
);
   import lcs_pkg::*;

   logic signed [2*EW-1:0]   p_ff [6];
   elem_type                 r1_ff [3];
   logic signed [CW-1:0]     c_ff [3];
   elem_type                 r2_ff [3];
   logic signed [LO_W+EW:0]  lo_ff [3];
   logic signed [2*EW-1:0]   hi_ff [3];
   det_type                  t_ff [3];
   det_type                  det_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= m[4] * m[8];
         p_ff[1] <= m[5] * m[7];
         p_ff[2] <= m[3] * m[8];
         p_ff[3] <= m[5] * m[6];
         p_ff[4] <= m[3] * m[7];
         p_ff[5] <= m[4] * m[6];
         for (int k = 0; k < 3; k++) begin
            r1_ff[k] <= m[k];
            c_ff[k]  <= CW'(p_ff[2*k]) - CW'(p_ff[2*k+1]);
            r2_ff[k] <= r1_ff[k];
            lo_ff[k] <= $signed({1'b0, c_ff[k][LO_W-1:0]}) * r2_ff[k];
            hi_ff[k] <= $signed(c_ff[k][CW-1:LO_W]) * r2_ff[k];
            t_ff[k]  <= (DETW'(hi_ff[k]) <<< LO_W) + DETW'(lo_ff[k]);
         end
         det_ff <= t_ff[0] - t_ff[1] + t_ff[2];
      end
   end

   assign det = det_ff;

endmodule

[design/lcs_div.sv]
module lcs_div (
   input  logic                     clock,
   input  logic                     en,
   input  lcs_pkg::det_type         num,
   input  lcs_pkg::det_type         det,
   output logic [lcs_pkg::EW-1:0]   res,
   output logic                     ovf
);
   import lcs_pkg::*;

   logic              neg_a_ff;
   logic [DETW-1:0]   nmag_ff;
   logic [DETW-1:0]   dmag_a_ff;
   logic [RW-1:0]     rem_ff [QBITS+1];
   logic [QBITS-1:0]  q_ff   [QBITS+1];
   logic [DETW-1:0]   d_ff   [QBITS+1];
   logic              neg_ff [QBITS+1];
   logic              big_ff [QBITS+1];
   logic [EW-1:0]     res_ff;
   logic              ovf_ff;
   logic [RW-1:0]     rem0_in;
   logic [QBITS-1:0]  qf;
   logic              nf;
   logic              bf;

   assign rem0_in = RW'(nmag_ff) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff  <= !(num[DETW-1] ^ det[DETW-1]);
         nmag_ff   <= num[DETW-1] ? DETW'(-num) : DETW'(num);
         dmag_a_ff <= det[DETW-1] ? DETW'(-det) : DETW'(det);
         rem_ff[0] <= rem0_in;
         q_ff[0]   <= '0;
         d_ff[0]   <= dmag_a_ff;
         neg_ff[0] <= neg_a_ff;
         big_ff[0] <= rem0_in >= (RW'(dmag_a_ff) << QBITS);
      end
   end

   for (genvar k = 0; k < QBITS; k++) begin : g_step
      logic [RW-1:0] dsh;
      logic          ge;
      assign dsh = RW'(d_ff[k]) << (QBITS - 1 - k);
      assign ge  = rem_ff[k] >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? rem_ff[k] - dsh : rem_ff[k];
            q_ff[k+1]   <= {q_ff[k][QBITS-2:0], ge};
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            big_ff[k+1] <= big_ff[k];
         end
      end
   end

   assign qf = q_ff[QBITS];
   assign nf = neg_ff[QBITS];
   assign bf = big_ff[QBITS];

   always_ff @(posedge clock) begin
      if (en) begin
         if (nf) begin
            if (bf || (qf[QBITS-1] && (|qf[QBITS-2:0]))) begin
               res_ff <= {1'b1, {(EW-1){1'b0}}};
               ovf_ff <= 1'b1;
            end else begin
               res_ff <= EW'(-qf);
               ovf_ff <= 1'b0;
            end
         end else begin
            if (bf || qf[QBITS-1]) begin
               res_ff <= {1'b0, {(EW-1){1'b1}}};
               ovf_ff <= 1'b1;
            end else begin
               res_ff <= EW'(qf);
               ovf_ff <= 1'b0;
            end
         end
      end
   end

   assign res = res_ff;
   assign ovf = ovf_ff;

endmodule

[design/linear_solve_3x3_cramer.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  row0_col0..row2_col2, shift_x..shift_z
// rsp       out        rsp_valid/rsp_stall  sol_x, sol_y, sol_z, singular, overflow
// csr       in/out     psel/penable/pready  singular_limit at byte address 0
// One transfer is taken per cycle unless a stalled output holds the pipeline.
// The 32-stage restoring divider produces one quotient bit per stage.
// Reset is synchronous; it clears the valid bits and sets the limit register to one.
// A stalled output freezes the whole pipeline and stalls the request channel.
module linear_solve_3x3_cramer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lcs_pkg::elem_type    req_row0_col0,
   input  lcs_pkg::elem_type    req_row0_col1,
   input  lcs_pkg::elem_type    req_row0_col2,
   input  lcs_pkg::elem_type    req_row1_col0,
   input  lcs_pkg::elem_type    req_row1_col1,
   input  lcs_pkg::elem_type    req_row1_col2,
   input  lcs_pkg::elem_type    req_row2_col0,
   input  lcs_pkg::elem_type    req_row2_col1,
   input  lcs_pkg::elem_type    req_row2_col2,
   input  lcs_pkg::elem_type    req_shift_x,
   input  lcs_pkg::elem_type    req_shift_y,
   input  lcs_pkg::elem_type    req_shift_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lcs_pkg::elem_type    rsp_sol_x,
   output lcs_pkg::elem_type    rsp_sol_y,
   output lcs_pkg::elem_type    rsp_sol_z,
   output logic                 rsp_singular,
   output logic                 rsp_overflow,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [lcs_pkg::AW-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import lcs_pkg::*;

   logic              en;
   logic [LIM_W-1:0]  lim_ff;
   logic [PIPE_LAT-1:0] vld_ff;
   elem_type          a [9];
   elem_type          t [3];
   elem_type          m [4][9];
   det_type           dets [4];
   logic [EW-1:0]     res [3];
   logic              ovf [3];
   logic [DETW-1:0]   dabs_ff;
   logic              sing_ff [DIV_LAT-1];
   logic              rsp_valid_ff;
   elem_type          sol_ff [3];
   logic              singular_ff;
   logic              overflow_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = reset || !en;
   assign pready    = 1'b1;
   assign prdata    = (paddr[AW-1:2] == REG_SINGULAR_LIMIT[AW-1:2]) ? {1'b0, lim_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LIM_W'(1);
      end else if (psel && penable && pwrite && pready &&
                   paddr[AW-1:2] == REG_SINGULAR_LIMIT[AW-1:2]) begin
         lim_ff <= pwdata[LIM_W-1:0];
      end
   end

   assign a = '{req_row0_col0, req_row0_col1, req_row0_col2,
                req_row1_col0, req_row1_col1, req_row1_col2,
                req_row2_col0, req_row2_col1, req_row2_col2};
   assign t = '{req_shift_x, req_shift_y, req_shift_z};

   for (genvar l = 0; l < 4; l++) begin : g_lane
      for (genvar e = 0; e < 9; e++) begin : g_el
         if (l > 0 && (e % 3) == l - 1) begin : g_t
            assign m[l][e] = t[e / 3];
         end else begin : g_a
            assign m[l][e] = a[e];
         end
      end
      lcs_det3 u_det (
         .clock (clock),
         .en    (en),
         .m     (m[l]),
         .det   (dets[l])
      );
   end

   for (genvar c = 0; c < 3; c++) begin : g_div
      lcs_div u_div (
         .clock (clock),
         .en    (en),
         .num   (dets[c+1]),
         .det   (dets[0]),
         .res   (res[c]),
         .ovf   (ovf[c])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dabs_ff    <= dets[0][DETW-1] ? DETW'(-dets[0]) : DETW'(dets[0]);
         sing_ff[0] <= (dabs_ff == '0) || (dabs_ff < (DETW'(lim_ff) << (2 * FRAC_BITS)));
         for (int k = 1; k < DIV_LAT - 1; k++) begin
            sing_ff[k] <= sing_ff[k-1];
         end
         for (int c = 0; c < 3; c++) begin
            sol_ff[c] <= sing_ff[DIV_LAT-2] ? '0 : elem_type'(res[c]);
         end
         singular_ff <= sing_ff[DIV_LAT-2];
         overflow_ff <= !sing_ff[DIV_LAT-2] && (ovf[0] || ovf[1] || ovf[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[PIPE_LAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_LAT-1];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sol_x    = sol_ff[0];
   assign rsp_sol_y    = sol_ff[1];
   assign rsp_sol_z    = sol_ff[2];
   assign rsp_singular = singular_ff;
   assign rsp_overflow = overflow_ff;

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_sol_x == '0 && rsp_sol_y == '0 && rsp_sol_z == '0 && !rsp_overflow)
      else $error("singular result is not zero");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_sol_x == 32'sh7fffffff || rsp_sol_x == 32'sh80000000 ||
         rsp_sol_y == 32'sh7fffffff || rsp_sol_y == 32'sh80000000 ||
         rsp_sol_z == 32'sh7fffffff || rsp_sol_z == 32'sh80000000)
      else $error("overflow without a saturated component");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

[tb/linear_solve_3x3_cramer_tb.sv]
`timescale 1ns / 1ps

module linear_solve_3x3_cramer_tb;
   import lcs_pkg::*;

   localparam int SETTLE_CYCLES = PIPE_LAT + 20;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      elem_type a [9];
      elem_type t [3];
   } system_type;

   typedef struct {
      elem_type x;
      elem_type y;
      elem_type z;
      logic     sing;
      logic     ovf;
   } solution_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   elem_type req_a [9];
   elem_type req_t [3];
   logic rsp_valid;
   logic rsp_stall;
   elem_type rsp_sol_x, rsp_sol_y, rsp_sol_z;
   logic rsp_singular, rsp_overflow;
   logic psel, penable, pwrite;
   logic [AW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   logic [30:0] limit_model;
   solution_type solution_queue [$];
   int error_count;
   int idle_cycles;
   bit rx_idle_enable;
   bit rx_hold;

   linear_solve_3x3_cramer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_row0_col0(req_a[0]), .req_row0_col1(req_a[1]), .req_row0_col2(req_a[2]),
      .req_row1_col0(req_a[3]), .req_row1_col1(req_a[4]), .req_row1_col2(req_a[5]),
      .req_row2_col0(req_a[6]), .req_row2_col1(req_a[7]), .req_row2_col2(req_a[8]),
      .req_shift_x(req_t[0]), .req_shift_y(req_t[1]), .req_shift_z(req_t[2]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sol_x(rsp_sol_x), .rsp_sol_y(rsp_sol_y), .rsp_sol_z(rsp_sol_z),
      .rsp_singular(rsp_singular), .rsp_overflow(rsp_overflow),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic signed [127:0] det3(input logic signed [127:0] m [9]);
      det3 = m[0] * (m[4] * m[8] - m[5] * m[7])
           - m[1] * (m[3] * m[8] - m[5] * m[6])
           + m[2] * (m[3] * m[7] - m[4] * m[6]);
   endfunction

   function automatic solution_type solve_cramer(input system_type s);
      logic signed [127:0] m [9];
      logic signed [127:0] det, num;
      logic [127:0] dmag, nmag, q, lim;
      logic neg;
      solution_type r;
      elem_type comp [3];
      r.sing = 1'b0;
      r.ovf = 1'b0;
      for (int i = 0; i < 9; i++) m[i] = s.a[i];
      det = det3(m);
      dmag = det < 0 ? -det : det;
      lim = {97'd0, limit_model} << (2 * FRAC_BITS);
      if (det == 0 || dmag < lim) begin
         r.x = 0; r.y = 0; r.z = 0; r.sing = 1'b1;
         return r;
      end
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 9; i++) m[i] = s.a[i];
         for (int i = 0; i < 3; i++) m[i * 3 + c] = s.t[i];
         num = det3(m);
         neg = !((num < 0) != (det < 0));
         nmag = num < 0 ? -num : num;
         q = (nmag << FRAC_BITS) / dmag;
         if (neg) begin
            if (q > 128'h8000_0000) begin
               comp[c] = 32'sh8000_0000; r.ovf = 1'b1;
            end else begin
               comp[c] = -q[31:0];
            end
         end else begin
            if (q > 128'h7FFF_FFFF) begin
               comp[c] = 32'sh7FFF_FFFF; r.ovf = 1'b1;
            end else begin
               comp[c] = q[31:0];
            end
         end
      end
      r.x = comp[0]; r.y = comp[1]; r.z = comp[2];
      return r;
   endfunction

   task automatic send_system(input system_type s);
      while ($urandom_range(0, 5) == 0 && rx_idle_enable) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a <= s.a;
      req_t <= s.t;
      do @(posedge clock); while (req_stall);
      solution_queue.push_back(solve_cramer(s));
   endtask

   // Every task returns just past a clock edge, so the next one drives at once.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (solution_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= REG_SINGULAR_LIMIT; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      limit_model = value[30:0];
   endtask

   function automatic elem_type rand_elem(input int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 2 * 65536)) - 65536;
         2: return $signed($urandom_range(0, 16)) <<< 16;
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   function automatic system_type random_system();
      system_type s;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         s.a[i] = rand_elem(mode < 4 ? 1 : mode < 7 ? 0 : mode < 9 ? 2 : 3);
         if (mode == 9 && $urandom_range(0, 2) == 0) s.a[i] = rand_elem(0);
      end
      if (mode == 8) for (int i = 0; i < 3; i++) s.a[3 + i] = s.a[i];
      for (int i = 0; i < 3; i++)
         s.t[i] = rand_elem($urandom_range(0, 3) == 0 ? 0 : mode < 4 ? 1 : 0);
      return s;
   endfunction

   function automatic system_type diag_system(input elem_type d, input elem_type sh);
      system_type s;
      for (int i = 0; i < 9; i++) s.a[i] = 0;
      s.a[0] = d; s.a[4] = d; s.a[8] = d;
      for (int i = 0; i < 3; i++) s.t[i] = sh;
      return s;
   endfunction

   task automatic test_directed();
      system_type s;
      send_system(diag_system(32'sh0001_0000, 32'sh0002_0000));
      send_system(diag_system(32'sh0001_0000, 32'sh8000_0000));
      send_system(diag_system(32'sh0001_0000, 32'sh7FFF_FFFF));
      send_system(diag_system(32'sh0000_0001, 32'sh7FFF_FFFF));
      send_system(diag_system(32'sh8000_0000, 32'sh8000_0000));
      send_system(diag_system(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      send_system(diag_system(32'sh8000_0000, 32'sh7FFF_FFFF));
      send_system(diag_system(32'sh0, 32'sh0001_0000));
      send_system(diag_system(32'sh0000_0100, 32'sh0001_0000));
      send_system(diag_system(32'sh0001_0000, 32'sh0000_0000));
      s = diag_system(32'sh0003_0000, 32'shFFFF_0000);
      s.a[1] = 32'sh0001_0000; s.a[5] = 32'shFFFE_0000; s.a[6] = 32'sh0000_8000;
      send_system(s);
      for (int i = 0; i < 9; i++) s.a[i] = 32'sh8000_0000;
      send_system(s);
      for (int i = 0; i < 9; i++) s.a[i] = 32'sh7FFF_FFFF;
      send_system(s);
      for (int i = 0; i < 12; i++) send_system(random_system());
      wait_drained();
   endtask

   task automatic test_limits();
      logic [31:0] settings [5];
      settings = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0002, 32'h5555_5555};
      foreach (settings[k]) begin
         write_limit(settings[k]);
         send_system(diag_system(32'sh0, 32'sh1));
         send_system(diag_system(32'sh0001_0000, 32'sh0003_0000));
         send_system(diag_system(32'sh0000_0100, 32'sh0001_0000));
         send_system(diag_system(32'sh0100_0000, 32'sh1234_5678));
         for (int i = 0; i < 16; i++) send_system(random_system());
         wait_drained();
      end
      write_limit(32'h0000_0001);
   endtask

   task automatic test_backpressure();
      rx_hold = 1'b1;
      for (int i = 0; i < 60; i++) send_system(random_system());
      wait_drained();
   endtask

   task automatic test_random(input int count, input bit with_idle);
      rx_idle_enable = with_idle;
      for (int i = 0; i < count; i++) send_system(random_system());
   endtask

   // Receiver: random stall bursts, plus one long hold-off when requested.
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rx_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            rx_hold = 1'b0;
         end else if (rx_idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      solution_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (solution_queue.size() == 0) begin
            $error("unexpected result transfer");
            error_count++;
         end else begin
            e = solution_queue.pop_front();
            if (rsp_sol_x !== e.x) begin
               $error("sol_x expected %0d actual %0d", e.x, rsp_sol_x); error_count++;
            end
            if (rsp_sol_y !== e.y) begin
               $error("sol_y expected %0d actual %0d", e.y, rsp_sol_y); error_count++;
            end
            if (rsp_sol_z !== e.z) begin
               $error("sol_z expected %0d actual %0d", e.z, rsp_sol_z); error_count++;
            end
            if (rsp_singular !== e.sing) begin
               $error("singular expected %0b actual %0b", e.sing, rsp_singular);
               error_count++;
            end
            if (rsp_overflow !== e.ovf) begin
               $error("overflow expected %0b actual %0b", e.ovf, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("linear_solve_3x3_cramer_tb: done, errors");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      rx_idle_enable = 1'b1;
      rx_hold = 1'b0;
      limit_model = 31'd1;
      reset = 1'b1;
      req_valid = 1'b0;
      for (int i = 0; i < 9; i++) req_a[i] = '0;
      for (int i = 0; i < 3; i++) req_t[i] = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits();
      test_backpressure();
      test_random(300, 1'b1);
      wait_drained();
      test_random(80, 1'b0);
      wait_drained();
      if (error_count == 0)
         $display("linear_solve_3x3_cramer_tb: done, clean");
      else
         $display("linear_solve_3x3_cramer_tb: done, errors");
      $finish;
   end

endmodule
